// ===== src/wspm_pkg.sv =====
package wspm_pkg;

    localparam int PERIOD_W   = 32;
    localparam int TRIG_W     = 8;
    localparam int DEN_W      = PERIOD_W + TRIG_W;
    localparam int US_W       = 20;
    localparam int US_PER_SEC = 1000000;
    localparam int SPEED_W    = 28;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int FRAC_BITS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGERS_PER_REV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US       = 1'b1;

    localparam logic [TRIG_W-1:0]   TRIG_RESET    = 8'd1;
    localparam logic [PERIOD_W-1:0] TIMEOUT_RESET = 32'd1000000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

endpackage

// ===== src/wspm_mul.sv =====
module wspm_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [wspm_pkg::PERIOD_W-1:0]     i_period,
    input  logic [wspm_pkg::TRIG_W-1:0]       i_trig,
    output logic [wspm_pkg::DEN_W-1:0]        o_product,
    output wspm_pkg::t_unit_status            o_status
);
    import wspm_pkg::*;

    localparam int CNT_W = $clog2(TRIG_W);

    logic [DEN_W-1:0]  r_acc;
    logic [DEN_W-1:0]  r_mcand;
    logic [TRIG_W-1:0] r_mplier;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    // one multiplier bit per cycle, lsb first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= DEN_W'(i_period);
            r_mplier <= i_trig;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[DEN_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[TRIG_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TRIG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_product     = r_acc;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// ===== src/wspm_div.sv =====
module wspm_div #(
    parameter int NUM_W = wspm_pkg::US_W + wspm_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [NUM_W-1:0]              i_num,
    input  logic [wspm_pkg::DEN_W-1:0]    i_den,
    output logic [NUM_W-1:0]              o_quo,
    output wspm_pkg::t_unit_status        o_status
);
    import wspm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // restoring division, one quotient bit per cycle; numerator shifts out as quotient shifts in
    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo         = r_q;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// ===== src/wheel_speed_period_meter_unit.sv =====
// when not timed out, an accepted tick runs through the serial multiplier (S_MUL)
//   and then the serial divider (S_DIV) before S_FIN loads the result
// timed-out ticks skip both and go straight to S_FIN, which loads a zero result
// ticks are taken one at a time, a new one only back in S_IDLE; a stalled result holds the next
// reset: synchronous active low; count and stamps clear, triggers 1, timeout 1000000
module wheel_speed_period_meter_unit #(
    parameter int FRAC_BITS = wspm_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wspm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wspm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_edge_seen,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [wspm_pkg::SPEED_W-1:0]      o_speed_rps_q8,
    output logic                              o_timed_out
);
    import wspm_pkg::*;

    localparam int NUM_W = US_W + FRAC_BITS;
    localparam logic [NUM_W-1:0] NUM_VAL = NUM_W'(US_PER_SEC) << FRAC_BITS;
    localparam logic [63:0] NUM_64    = 64'(US_PER_SEC) << FRAC_BITS;
    localparam logic [63:0] FIELD_MAX = (64'd1 << SPEED_W) - 64'd1;
    localparam logic [63:0] SPEED_MAX = (NUM_64 > FIELD_MAX) ? FIELD_MAX : NUM_64;

    t_state r_state, n_state;

    logic [TRIG_W-1:0]   r_trig;
    logic [PERIOD_W-1:0] r_timeout;
    logic [PERIOD_W-1:0] r_now;
    logic [PERIOD_W-1:0] r_prev;
    logic [PERIOD_W-1:0] r_curr;
    logic                r_tout;

    logic                r_out_valid;
    logic [SPEED_W-1:0]  r_speed;
    logic                r_out_tout;

    logic                accept;
    logic [PERIOD_W-1:0] n_prev;
    logic [PERIOD_W-1:0] n_curr;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] since;
    logic                tout_now;

    logic                mul_start;
    logic                div_start;
    logic                load_out;
    logic                out_free;
    logic [DEN_W-1:0]    product;
    logic [NUM_W-1:0]    quo;
    logic [63:0]         quo_64;
    logic [SPEED_W-1:0]  speed_sat;
    t_unit_status        mul_st;
    t_unit_status        div_st;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // the edge moves the stamps before the result is worked out
    always_comb begin
        n_prev   = i_edge_seen ? r_curr : r_prev;
        n_curr   = i_edge_seen ? r_now  : r_curr;
        period   = n_curr - n_prev;
        since    = r_now - n_prev;
        tout_now = (since >= r_timeout);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig    <= TRIG_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TRIGGERS_PER_REV: r_trig    <= i_cfg_data[TRIG_W-1:0];
                REG_TIMEOUT_US:       r_timeout <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now  <= '0;
            r_prev <= '0;
            r_curr <= '0;
            r_tout <= 1'b0;
        end else if (accept) begin
            r_now  <= r_now + 1'b1;
            r_prev <= n_prev;
            r_curr <= n_curr;
            r_tout <= tout_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = tout_now ? S_FIN : S_MUL;
                end
            end
            S_MUL: begin
                if (mul_st.done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_st.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                mul_start  = accept && !tout_now;
            end
            S_MUL:   div_start = mul_st.done;
            S_DIV:   ;
            S_FIN:   load_out  = out_free;
            default: ;
        endcase
    end

    wspm_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_period  (period),
        .i_trig    (r_trig),
        .o_product (product),
        .o_status  (mul_st)
    );

    wspm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (NUM_VAL),
        .i_den    (product),
        .o_quo    (quo),
        .o_status (div_st)
    );

    // a zero divisor leaves an all-ones quotient, which saturates like any overflow
    always_comb begin
        quo_64    = 64'(quo);
        speed_sat = (quo_64 > SPEED_MAX) ? SPEED_MAX[SPEED_W-1:0] : quo_64[SPEED_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_speed    <= r_tout ? '0 : speed_sat;
            r_out_tout <= r_tout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_speed_rps_q8 = r_speed;
    assign o_timed_out    = r_out_tout;

endmodule
